### rtl/dmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maze carver package
// Shared constants, command codes, control structs and the size rule used by
// the maze carver modules.
// ----------------------------------------------------------------------------
package dmc_pkg;

   // Default geometry of the grid and of the path stack.
   localparam int DEF_MAX_WIDTH   = 64;
   localparam int DEF_MAX_HEIGHT  = 64;
   localparam int DEF_STACK_DEPTH = 1024;

   // Widths fixed by the external interface.
   localparam int FIELD_W  = 6;
   localparam int PICK_W   = 8;
   localparam int KIND_W   = 2;
   localparam int SIZE_W   = 9;

   // Reset value of both size requests and the smallest legal side.
   localparam logic [FIELD_W-1:0] REQ_RESET = 6'd15;
   localparam logic [SIZE_W-1:0]  MIN_SIDE  = 9'd3;

   // Transaction kinds.
   localparam logic [KIND_W-1:0] KIND_RESTART = 2'd0;
   localparam logic [KIND_W-1:0] KIND_STEP    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ    = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_WIDTH_IDX  = 1'b0;
   localparam logic CSR_HEIGHT_IDX = 1'b1;

   // Neighbour offsets, checked in the order up, right, down, left.
   localparam logic signed [2:0] DCOL [4] = '{3'sd0, 3'sd2, 3'sd0, -3'sd2};
   localparam logic signed [2:0] DROW [4] = '{-3'sd2, 3'sd0, 3'sd2, 3'sd0};

   // Commands to the grid store.
   typedef struct packed {
      logic sweep_start;
      logic wr_en;
      logic wr_wall;
   } grid_ctrl_type;

   // Commands to the path stack.
   typedef struct packed {
      logic init;
      logic push;
      logic pop;
   } stack_ctrl_type;

   // Status from the path stack.
   typedef struct packed {
      logic empty;
      logic single;
   } stack_stat_type;

   // Rounds an even request up to odd, clamps it to at least three and to the
   // largest odd side that fits.
   function automatic logic [SIZE_W-1:0] size_from_request(input logic [FIELD_W-1:0] req,
                                                           input logic [SIZE_W-1:0]  top);
      logic [SIZE_W-1:0] s;
      s = {{(SIZE_W-FIELD_W){1'b0}}, req} | 9'd1;
      if (s < MIN_SIDE) s = MIN_SIDE;
      if (s > top) s = top;
      return s;
   endfunction

endpackage

### rtl/dmc_grid_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maze carver grid store
// One-bit-per-cell wall memory with a single write and a single registered
// read port, and a sweep engine that refills a rectangle with walls.
// ----------------------------------------------------------------------------
module dmc_grid_store
   import dmc_pkg::*;
#(
   parameter int CW = 6,
   parameter int RW = 6
) (
   input  logic          clock,
   input  logic          reset,
   input  grid_ctrl_type ctrl,
   input  logic [CW-1:0] wr_col,
   input  logic [RW-1:0] wr_row,
   input  logic [CW-1:0] rd_col,
   input  logic [RW-1:0] rd_row,
   input  logic [CW-1:0] sweep_last_col,
   input  logic [RW-1:0] sweep_last_row,
   output logic          rd_wall,
   output logic          sweeping
);

   localparam int DEPTH = 2 ** (CW + RW);

   logic          mem [DEPTH];
   logic          rd_wall_ff;
   logic          sweeping_ff;
   logic [CW-1:0] sw_col_ff;
   logic [RW-1:0] sw_row_ff;
   logic [CW-1:0] last_col_ff;
   logic [RW-1:0] last_row_ff;

   // Sweep sequencer: after reset it covers the whole memory, after a restart
   // only the rectangle of the new maze.
   always_ff @(posedge clock) begin
      if (reset) begin
         sweeping_ff <= 1'b1;
         sw_col_ff   <= '0;
         sw_row_ff   <= '0;
         last_col_ff <= '1;
         last_row_ff <= '1;
      end else if (sweeping_ff) begin
         if (sw_col_ff == last_col_ff) begin
            sw_col_ff <= '0;
            sw_row_ff <= sw_row_ff + RW'(1);
            if (sw_row_ff == last_row_ff) begin
               sweeping_ff <= 1'b0;
            end
         end else begin
            sw_col_ff <= sw_col_ff + CW'(1);
         end
      end else if (ctrl.sweep_start) begin
         sweeping_ff <= 1'b1;
         sw_col_ff   <= '0;
         sw_row_ff   <= '0;
         last_col_ff <= sweep_last_col;
         last_row_ff <= sweep_last_row;
      end
   end

   // Wall memory: the sweep has the write port while it runs.
   always_ff @(posedge clock) begin
      if (sweeping_ff) begin
         mem[{sw_row_ff, sw_col_ff}] <= 1'b1;
      end else if (ctrl.wr_en) begin
         mem[{wr_row, wr_col}] <= ctrl.wr_wall;
      end
      rd_wall_ff <= mem[{rd_row, rd_col}];
   end

   assign rd_wall  = rd_wall_ff;
   assign sweeping = sweeping_ff;

endmodule

### rtl/dmc_path_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maze carver path stack
// Memory of visited cells with a fill count; the top entry is read back
// continuously through a registered read port.
// ----------------------------------------------------------------------------
module dmc_path_stack
   import dmc_pkg::*;
#(
   parameter int CW    = 6,
   parameter int RW    = 6,
   parameter int DEPTH = 1024
) (
   input  logic           clock,
   input  logic           reset,
   input  stack_ctrl_type ctrl,
   input  logic [CW-1:0]  push_col,
   input  logic [RW-1:0]  push_row,
   output logic [CW-1:0]  top_col,
   output logic [RW-1:0]  top_row,
   output stack_stat_type stat
);

   localparam int AW = $clog2(DEPTH);
   localparam int NW = $clog2(DEPTH + 1);

   logic [CW+RW-1:0] mem [DEPTH];
   logic [CW+RW-1:0] top_ff;
   logic [NW-1:0]    count_ff;
   logic [NW-1:0]    count_dec;
   logic             has_room;

   assign count_dec = count_ff - NW'(1);
   assign has_room  = (count_ff < NW'(DEPTH));

   // Fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctrl.init) begin
         count_ff <= NW'(1);
      end else if (ctrl.push && has_room) begin
         count_ff <= count_ff + NW'(1);
      end else if (ctrl.pop) begin
         count_ff <= count_dec;
      end
   end

   // Entry memory; the seed cell (1,1) goes to the bottom on a restart.
   always_ff @(posedge clock) begin
      if (ctrl.init) begin
         mem[AW'(0)] <= {RW'(1), CW'(1)};
      end else if (ctrl.push && has_room) begin
         mem[count_ff[AW-1:0]] <= {push_row, push_col};
      end
      top_ff <= mem[count_dec[AW-1:0]];
   end

   assign top_col     = top_ff[CW-1:0];
   assign top_row     = top_ff[CW+RW-1:CW];
   assign stat.empty  = (count_ff == '0);
   assign stat.single = (count_ff == NW'(1));

endmodule

### rtl/dfs_maze_carver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maze carver top level
// Randomised depth-first maze carving over a wall grid held in memory.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; every transaction
// gives exactly one result, shown for one cycle with rsp_valid, and the
// receiver cannot hold it off. After reset the block is busy while the grid
// memory is filled with walls. A restart sweeps the new W by H maze
// rectangle, one cell a cycle, before it answers. In a carving step the four
// neighbour cells are read one after another through the single read port of
// the grid memory, then the gap and the new cell are written in turn.
// ----------------------------------------------------------------------------
module dfs_maze_carver_top
   import dmc_pkg::*;
#(
   parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
   parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [KIND_W-1:0]  req_kind,
   input  logic [PICK_W-1:0]  req_random_pick,
   input  logic [FIELD_W-1:0] req_read_column,
   input  logic [FIELD_W-1:0] req_read_row,
   output logic               rsp_valid,
   output logic               rsp_carved,
   output logic               rsp_popped,
   output logic               rsp_finished,
   output logic [FIELD_W-1:0] rsp_new_column,
   output logic [FIELD_W-1:0] rsp_new_row,
   output logic [FIELD_W-1:0] rsp_gap_column,
   output logic [FIELD_W-1:0] rsp_gap_row,
   output logic               rsp_cell_wall,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [FIELD_W-1:0] csr_wdata
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int SW    = ((CW > RW) ? CW : RW) + 2;
   localparam int TOP_W = (MAX_WIDTH % 2 == 0) ? MAX_WIDTH - 1 : MAX_WIDTH;
   localparam int TOP_H = (MAX_HEIGHT % 2 == 0) ? MAX_HEIGHT - 1 : MAX_HEIGHT;
   localparam int CMP_W = 16;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SWEEP, ST_SEED, ST_READ,
      ST_N0, ST_N1, ST_N2, ST_N3, ST_PICK,
      ST_GAP, ST_CELL, ST_ENTR, ST_EXIT
   } state_type;

   state_type          state_ff;
   logic [FIELD_W-1:0] width_req_ff;
   logic [FIELD_W-1:0] height_req_ff;
   logic [CW-1:0]      maze_w_ff;
   logic [RW-1:0]      maze_h_ff;
   logic [CW-1:0]      maze_w_in;
   logic [RW-1:0]      maze_h_in;
   logic               done_ff;
   logic               popped_ff;
   logic               rd_in_ff;
   logic [PICK_W-1:0]  pick_ff;
   logic [2:0]         cand_ff;
   logic [1:0]         dir_ff;

   logic               rsp_valid_ff;
   logic               rsp_carved_ff;
   logic               rsp_popped_ff;
   logic               rsp_finished_ff;
   logic [FIELD_W-1:0] rsp_new_column_ff;
   logic [FIELD_W-1:0] rsp_new_row_ff;
   logic [FIELD_W-1:0] rsp_gap_column_ff;
   logic [FIELD_W-1:0] rsp_gap_row_ff;
   logic               rsp_cell_wall_ff;

   grid_ctrl_type      grid_ctrl;
   stack_ctrl_type     stack_ctrl;
   stack_stat_type     stack_stat;
   logic [CW-1:0]      g_wr_col;
   logic [RW-1:0]      g_wr_row;
   logic [CW-1:0]      g_rd_col;
   logic [RW-1:0]      g_rd_row;
   logic               g_rd_wall;
   logic               g_sweeping;
   logic [CW-1:0]      top_col;
   logic [RW-1:0]      top_row;

   logic signed [SW-1:0] tc_s;
   logic signed [SW-1:0] tr_s;
   logic signed [SW-1:0] wl_s;
   logic signed [SW-1:0] hl_s;
   logic signed [SW-1:0] nc_s [4];
   logic signed [SW-1:0] nr_s [4];
   logic signed [SW-1:0] gsum_c [4];
   logic signed [SW-1:0] gsum_r [4];
   logic [3:0]           inb;
   logic [CW-1:0]        nb_col [4];
   logic [RW-1:0]        nb_row [4];
   logic [CW-1:0]        gap_col [4];
   logic [RW-1:0]        gap_row [4];

   logic [3:0]           cand;
   logic [2:0]           n_cand;
   logic [PICK_W+2:0]    prod;
   logic [2:0]           sel;
   logic [1:0]           pick_dir;
   logic                 accept;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE) || g_sweeping;

   // Effective size from the current requests, latched on a restart.
   assign maze_w_in = CW'(size_from_request(width_req_ff, SIZE_W'(TOP_W)));
   assign maze_h_in = RW'(size_from_request(height_req_ff, SIZE_W'(TOP_H)));

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_req_ff  <= REQ_RESET;
         height_req_ff <= REQ_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_WIDTH_IDX:  width_req_ff  <= csr_wdata;
            CSR_HEIGHT_IDX: height_req_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Neighbour coordinates, bounds and gap cells around the stack top.
   always_comb begin
      tc_s = $signed(SW'(top_col));
      tr_s = $signed(SW'(top_row));
      wl_s = $signed(SW'(maze_w_ff)) - SW'(1);
      hl_s = $signed(SW'(maze_h_ff)) - SW'(1);
      for (int k = 0; k < 4; k++) begin
         nc_s[k]    = tc_s + SW'(DCOL[k]);
         nr_s[k]    = tr_s + SW'(DROW[k]);
         inb[k]     = (nc_s[k] > 0) && (nr_s[k] > 0) && (nc_s[k] < wl_s) && (nr_s[k] < hl_s);
         nb_col[k]  = nc_s[k][CW-1:0];
         nb_row[k]  = nr_s[k][RW-1:0];
         gsum_c[k]  = tc_s + nc_s[k];
         gsum_r[k]  = tr_s + nr_s[k];
         gap_col[k] = gsum_c[k][CW:1];
         gap_row[k] = gsum_r[k][RW:1];
      end
   end

   // Candidate count and the choice (pick * count) >> 8 among them.
   always_comb begin
      logic [2:0] acc;
      logic       found;
      acc      = '0;
      found    = 1'b0;
      pick_dir = '0;
      cand     = {g_rd_wall & inb[3], cand_ff};
      n_cand   = 3'(cand[0]) + 3'(cand[1]) + 3'(cand[2]) + 3'(cand[3]);
      prod     = {3'b000, pick_ff} * {{PICK_W{1'b0}}, n_cand};
      sel      = prod[PICK_W+2:PICK_W];
      for (int k = 0; k < 4; k++) begin
         if (cand[k] && !found && (acc == sel)) begin
            pick_dir = 2'(k);
            found    = 1'b1;
         end
         acc = acc + 3'(cand[k]);
      end
   end

   // Memory port steering for each state.
   always_comb begin
      grid_ctrl  = '0;
      stack_ctrl = '0;
      g_wr_col   = '0;
      g_wr_row   = '0;
      g_rd_col   = CW'(req_read_column);
      g_rd_row   = RW'(req_read_row);
      unique case (state_ff)
         ST_IDLE: begin
            grid_ctrl.sweep_start = accept && (req_kind == KIND_RESTART);
         end
         ST_SEED: begin
            grid_ctrl.wr_en = 1'b1;
            g_wr_col        = CW'(1);
            g_wr_row        = RW'(1);
            stack_ctrl.init = 1'b1;
         end
         ST_N0: begin
            g_rd_col = nb_col[0];
            g_rd_row = nb_row[0];
         end
         ST_N1: begin
            g_rd_col = nb_col[1];
            g_rd_row = nb_row[1];
         end
         ST_N2: begin
            g_rd_col = nb_col[2];
            g_rd_row = nb_row[2];
         end
         ST_N3: begin
            g_rd_col = nb_col[3];
            g_rd_row = nb_row[3];
         end
         ST_PICK: begin
            stack_ctrl.pop = (n_cand == '0);
         end
         ST_GAP: begin
            grid_ctrl.wr_en = 1'b1;
            g_wr_col        = gap_col[dir_ff];
            g_wr_row        = gap_row[dir_ff];
         end
         ST_CELL: begin
            grid_ctrl.wr_en = 1'b1;
            g_wr_col        = nb_col[dir_ff];
            g_wr_row        = nb_row[dir_ff];
            stack_ctrl.push = 1'b1;
         end
         ST_ENTR: begin
            grid_ctrl.wr_en = 1'b1;
            g_wr_col        = '0;
            g_wr_row        = RW'(1);
         end
         ST_EXIT: begin
            grid_ctrl.wr_en = 1'b1;
            g_wr_col        = maze_w_ff - CW'(1);
            g_wr_row        = maze_h_ff - RW'(2);
         end
         default: ;
      endcase
   end

   // Sequencer with the registered result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         maze_w_ff         <= CW'(size_from_request(REQ_RESET, SIZE_W'(TOP_W)));
         maze_h_ff         <= RW'(size_from_request(REQ_RESET, SIZE_W'(TOP_H)));
         done_ff           <= 1'b0;
         popped_ff         <= 1'b0;
         rd_in_ff          <= 1'b0;
         pick_ff           <= '0;
         cand_ff           <= '0;
         dir_ff            <= '0;
         rsp_valid_ff      <= 1'b0;
         rsp_carved_ff     <= 1'b0;
         rsp_popped_ff     <= 1'b0;
         rsp_finished_ff   <= 1'b0;
         rsp_new_column_ff <= '0;
         rsp_new_row_ff    <= '0;
         rsp_gap_column_ff <= '0;
         rsp_gap_row_ff    <= '0;
         rsp_cell_wall_ff  <= 1'b0;
      end else begin
         // A result lasts one cycle; every field is zero unless set below.
         rsp_valid_ff      <= 1'b0;
         rsp_carved_ff     <= 1'b0;
         rsp_popped_ff     <= 1'b0;
         rsp_finished_ff   <= 1'b0;
         rsp_new_column_ff <= '0;
         rsp_new_row_ff    <= '0;
         rsp_gap_column_ff <= '0;
         rsp_gap_row_ff    <= '0;
         rsp_cell_wall_ff  <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  case (req_kind)
                     KIND_RESTART: begin
                        maze_w_ff <= maze_w_in;
                        maze_h_ff <= maze_h_in;
                        state_ff  <= ST_SWEEP;
                     end
                     KIND_STEP: begin
                        pick_ff <= req_random_pick;
                        if (done_ff) begin
                           rsp_valid_ff    <= 1'b1;
                           rsp_finished_ff <= 1'b1;
                        end else if (stack_stat.empty) begin
                           popped_ff <= 1'b0;
                           state_ff  <= ST_ENTR;
                        end else begin
                           state_ff <= ST_N0;
                        end
                     end
                     KIND_READ: begin
                        rd_in_ff <= (CMP_W'(req_read_column) < CMP_W'(maze_w_ff)) &&
                                    (CMP_W'(req_read_row) < CMP_W'(maze_h_ff));
                        state_ff <= ST_READ;
                     end
                     default: begin
                        rsp_valid_ff <= 1'b1;
                     end
                  endcase
               end
            end
            ST_SWEEP: begin
               if (!g_sweeping) begin
                  state_ff <= ST_SEED;
               end
            end
            ST_SEED: begin
               done_ff      <= 1'b0;
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            ST_READ: begin
               rsp_valid_ff     <= 1'b1;
               rsp_cell_wall_ff <= rd_in_ff ? g_rd_wall : 1'b1;
               state_ff         <= ST_IDLE;
            end
            ST_N0: begin
               state_ff <= ST_N1;
            end
            ST_N1: begin
               cand_ff[0] <= g_rd_wall & inb[0];
               state_ff   <= ST_N2;
            end
            ST_N2: begin
               cand_ff[1] <= g_rd_wall & inb[1];
               state_ff   <= ST_N3;
            end
            ST_N3: begin
               cand_ff[2] <= g_rd_wall & inb[2];
               state_ff   <= ST_PICK;
            end
            ST_PICK: begin
               dir_ff <= pick_dir;
               if (n_cand != '0) begin
                  state_ff <= ST_GAP;
               end else if (stack_stat.single) begin
                  // Last entry popped: open entrance and exit before answering.
                  popped_ff <= 1'b1;
                  state_ff  <= ST_ENTR;
               end else begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_popped_ff <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            ST_GAP: begin
               state_ff <= ST_CELL;
            end
            ST_CELL: begin
               rsp_valid_ff      <= 1'b1;
               rsp_carved_ff     <= 1'b1;
               rsp_new_column_ff <= FIELD_W'(nb_col[dir_ff]);
               rsp_new_row_ff    <= FIELD_W'(nb_row[dir_ff]);
               rsp_gap_column_ff <= FIELD_W'(gap_col[dir_ff]);
               rsp_gap_row_ff    <= FIELD_W'(gap_row[dir_ff]);
               state_ff          <= ST_IDLE;
            end
            ST_ENTR: begin
               state_ff <= ST_EXIT;
            end
            ST_EXIT: begin
               done_ff         <= 1'b1;
               rsp_valid_ff    <= 1'b1;
               rsp_finished_ff <= 1'b1;
               rsp_popped_ff   <= popped_ff;
               state_ff        <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   dmc_grid_store #(
      .CW (CW),
      .RW (RW)
   ) u_grid (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (grid_ctrl),
      .wr_col         (g_wr_col),
      .wr_row         (g_wr_row),
      .rd_col         (g_rd_col),
      .rd_row         (g_rd_row),
      .sweep_last_col (maze_w_in - CW'(1)),
      .sweep_last_row (maze_h_in - RW'(1)),
      .rd_wall        (g_rd_wall),
      .sweeping       (g_sweeping)
   );

   dmc_path_stack #(
      .CW    (CW),
      .RW    (RW),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (stack_ctrl),
      .push_col (nb_col[dir_ff]),
      .push_row (nb_row[dir_ff]),
      .top_col  (top_col),
      .top_row  (top_row),
      .stat     (stack_stat)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_carved     = rsp_carved_ff;
   assign rsp_popped     = rsp_popped_ff;
   assign rsp_finished   = rsp_finished_ff;
   assign rsp_new_column = rsp_new_column_ff;
   assign rsp_new_row    = rsp_new_row_ff;
   assign rsp_gap_column = rsp_gap_column_ff;
   assign rsp_gap_row    = rsp_gap_row_ff;
   assign rsp_cell_wall  = rsp_cell_wall_ff;

endmodule

### rtl/dmc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maze carver port checker
// Watches the ports of the top level for results that cannot occur.
// ----------------------------------------------------------------------------
module dmc_checker
   import dmc_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               busy,
   input logic               rsp_valid,
   input logic               rsp_carved,
   input logic               rsp_popped,
   input logic               rsp_finished,
   input logic [FIELD_W-1:0] rsp_new_column,
   input logic [FIELD_W-1:0] rsp_new_row,
   input logic [FIELD_W-1:0] rsp_gap_column,
   input logic [FIELD_W-1:0] rsp_gap_row,
   input logic               rsp_cell_wall
);

   // The grid is refilled after reset, so no transaction is taken at once.
   a_busy_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("block not busy after reset");

   // A step either carves or backtracks, never both.
   a_carve_pop_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_carved && rsp_popped))
      else $error("carved and popped together");

   // A carving transaction neither finishes the maze nor reports a cell read.
   a_carve_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_carved) |-> (!rsp_finished && !rsp_cell_wall))
      else $error("carving result with finish or read bits");

   // Carved cells sit on odd coordinates and the gap shares a row or column.
   a_carve_geometry: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_carved) |-> (rsp_new_column[0] && rsp_new_row[0] &&
         ((rsp_gap_column == rsp_new_column) || (rsp_gap_row == rsp_new_row))))
      else $error("carved cell or gap misplaced");

endmodule

bind dfs_maze_carver_top dmc_checker u_dmc_checker (.*);

### tb/sv/dfs_maze_carver_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maze carver top level testbench
// Drives restart, carving step, cell read and unused kind transactions into the maze
// carver, keeps its own wall grid and path stack to work out every result,
// and checks each result as it appears. Directed cases cover power-on
// behaviour and the size extremes; random mazes of mostly small sizes follow.
// ----------------------------------------------------------------------------
module dfs_maze_carver_top_tb;
   import dmc_pkg::*;

   localparam int GRID_CELLS   = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
   localparam int RANDOM_ITEMS = 1200;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int SHOWN_ERRORS = 10;

   // One result transaction, in the order of the result ports.
   typedef struct packed {
      logic               carved;
      logic               popped;
      logic               finished;
      logic [FIELD_W-1:0] new_column;
      logic [FIELD_W-1:0] new_row;
      logic [FIELD_W-1:0] gap_column;
      logic [FIELD_W-1:0] gap_row;
      logic               cell_wall;
   } maze_answer_type;

   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               start           = 1'b0;
   logic               busy;
   logic [KIND_W-1:0]  req_kind        = '0;
   logic [PICK_W-1:0]  req_random_pick = '0;
   logic [FIELD_W-1:0] req_read_column = '0;
   logic [FIELD_W-1:0] req_read_row    = '0;
   logic               rsp_valid;
   logic               rsp_carved;
   logic               rsp_popped;
   logic               rsp_finished;
   logic [FIELD_W-1:0] rsp_new_column;
   logic [FIELD_W-1:0] rsp_new_row;
   logic [FIELD_W-1:0] rsp_gap_column;
   logic [FIELD_W-1:0] rsp_gap_row;
   logic               rsp_cell_wall;
   logic               csr_write       = 1'b0;
   logic               csr_index       = 1'b0;
   logic [FIELD_W-1:0] csr_wdata       = '0;

   // Testbench copy of the maze state.
   logic               wall_map [GRID_CELLS];
   int                 trail_col [DEF_STACK_DEPTH];
   int                 trail_row [DEF_STACK_DEPTH];
   int                 trail_depth;
   logic               maze_done;
   logic [FIELD_W-1:0] width_req;
   logic [FIELD_W-1:0] height_req;
   int                 maze_w;
   int                 maze_h;

   maze_answer_type    expected_answers [$];
   maze_answer_type    seen_answer;
   maze_answer_type    wanted_answer;
   int                 mismatches  = 0;
   int                 work_items  = 0;
   int                 idle_pct    = 0;
   int                 cycle_count = 0;

   dfs_maze_carver_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_random_pick (req_random_pick),
      .req_read_column (req_read_column),
      .req_read_row    (req_read_row),
      .rsp_valid       (rsp_valid),
      .rsp_carved      (rsp_carved),
      .rsp_popped      (rsp_popped),
      .rsp_finished    (rsp_finished),
      .rsp_new_column  (rsp_new_column),
      .rsp_new_row     (rsp_new_row),
      .rsp_gap_column  (rsp_gap_column),
      .rsp_gap_row     (rsp_gap_row),
      .rsp_cell_wall   (rsp_cell_wall),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // 20 ns clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Guard against a hang.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("dfs_maze_carver_top_tb NOT OK");
         $finish;
      end
   end

   // Odd side of at least three that fits within the given maximum.
   function automatic int side_for(input logic [FIELD_W-1:0] req, input int limit);
      int s;
      int top;
      s   = int'(req);
      top = (limit % 2 == 0) ? limit - 1 : limit;
      if (s % 2 == 0) s = s + 1;
      if (s < 3) s = 3;
      if (s > top) s = top;
      return s;
   endfunction

   function automatic int cell_at(input int col, input int row);
      return row * DEF_MAX_WIDTH + col;
   endfunction

   // Entrance on the left edge, exit on the right, and the maze is complete.
   function automatic void open_exits();
      wall_map[cell_at(0, 1)] = 1'b0;
      wall_map[cell_at(maze_w - 1, maze_h - 2)] = 1'b0;
      maze_done = 1'b1;
   endfunction

   function automatic void clear_maze_state();
      foreach (wall_map[i]) wall_map[i] = 1'b1;
      trail_depth = 0;
      maze_done   = 1'b0;
      width_req   = REQ_RESET;
      height_req  = REQ_RESET;
      maze_w      = side_for(width_req, DEF_MAX_WIDTH);
      maze_h      = side_for(height_req, DEF_MAX_HEIGHT);
   endfunction

   // Applies one transaction to the maze copy and returns the result it gives.
   function automatic maze_answer_type apply_command(input logic [KIND_W-1:0]  kind,
                                                     input logic [PICK_W-1:0]  pick,
                                                     input logic [FIELD_W-1:0] rcol,
                                                     input logic [FIELD_W-1:0] rrow);
      maze_answer_type ans;
      int cur_c, cur_r, nc, nr, gc, gr, n, sel;
      int cand_c [4];
      int cand_r [4];
      ans = '0;
      n   = 0;
      case (kind)
         KIND_RESTART: begin
            maze_w = side_for(width_req, DEF_MAX_WIDTH);
            maze_h = side_for(height_req, DEF_MAX_HEIGHT);
            foreach (wall_map[i]) wall_map[i] = 1'b1;
            wall_map[cell_at(1, 1)] = 1'b0;
            trail_col[0] = 1;
            trail_row[0] = 1;
            trail_depth  = 1;
            maze_done    = 1'b0;
         end
         KIND_STEP: begin
            if (maze_done) begin
               ans.finished = 1'b1;
            end else if (trail_depth == 0) begin
               open_exits();
               ans.finished = 1'b1;
            end else begin
               cur_c = trail_col[trail_depth - 1];
               cur_r = trail_row[trail_depth - 1];
               // Walled cells two away, looked at up, right, down, left.
               for (int k = 0; k < 4; k++) begin
                  nc = cur_c;
                  nr = cur_r;
                  case (k)
                     0: nr = cur_r - 2;
                     1: nc = cur_c + 2;
                     2: nr = cur_r + 2;
                     default: nc = cur_c - 2;
                  endcase
                  if (nc > 0 && nr > 0 && nc < maze_w - 1 && nr < maze_h - 1 &&
                      wall_map[cell_at(nc, nr)]) begin
                     cand_c[n] = nc;
                     cand_r[n] = nr;
                     n++;
                  end
               end
               if (n == 0) begin
                  // Dead end: backtrack, and finish once the trail is empty.
                  trail_depth--;
                  ans.popped = 1'b1;
                  if (trail_depth == 0) begin
                     open_exits();
                     ans.finished = 1'b1;
                  end
               end else begin
                  sel = (int'(pick) * n) >> 8;
                  nc  = cand_c[sel];
                  nr  = cand_r[sel];
                  gc  = (cur_c + nc) / 2;
                  gr  = (cur_r + nr) / 2;
                  wall_map[cell_at(gc, gr)] = 1'b0;
                  wall_map[cell_at(nc, nr)] = 1'b0;
                  // A full trail still carves but keeps no record of the cell.
                  if (trail_depth < DEF_STACK_DEPTH) begin
                     trail_col[trail_depth] = nc;
                     trail_row[trail_depth] = nr;
                     trail_depth++;
                  end
                  ans.carved     = 1'b1;
                  ans.new_column = nc[FIELD_W-1:0];
                  ans.new_row    = nr[FIELD_W-1:0];
                  ans.gap_column = gc[FIELD_W-1:0];
                  ans.gap_row    = gr[FIELD_W-1:0];
               end
            end
         end
         KIND_READ: begin
            if (int'(rcol) < maze_w && int'(rrow) < maze_h)
               ans.cell_wall = wall_map[cell_at(int'(rcol), int'(rrow))];
            else
               ans.cell_wall = 1'b1;
         end
         default: begin
         end
      endcase
      return ans;
   endfunction

   // Sends one transaction and records the result it should give.
   task automatic send_command(input logic [KIND_W-1:0]  kind,
                               input logic [PICK_W-1:0]  pick,
                               input logic [FIELD_W-1:0] rcol,
                               input logic [FIELD_W-1:0] rrow);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      start           = 1'b1;
      req_kind        = kind;
      req_random_pick = pick;
      req_read_column = rcol;
      req_read_row    = rrow;
      do @(posedge clock); while (busy !== 1'b0);
      if (kind == KIND_RESTART || kind == KIND_READ || (kind == KIND_STEP && !maze_done))
         work_items++;
      expected_answers.insert(expected_answers.size(), apply_command(kind, pick, rcol, rrow));
      @(negedge clock);
   endtask

   // Lets every outstanding result arrive so that the block is idle.
   task automatic settle_block();
      start = 1'b0;
      while (expected_answers.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [FIELD_W-1:0] value);
      csr_write = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_write = 1'b0;
      if (idx == CSR_WIDTH_IDX)
         width_req = value;
      else
         height_req = value;
   endtask

   task automatic report_mismatch(input string what, input maze_answer_type want,
                                  input maze_answer_type got);
      mismatches++;
      if (mismatches <= SHOWN_ERRORS) begin
         $display("%s at %0t: expected c=%0d p=%0d f=%0d new=(%0d,%0d) gap=(%0d,%0d) w=%0d",
                  what, $realtime, want.carved, want.popped, want.finished, want.new_column,
                  want.new_row, want.gap_column, want.gap_row, want.cell_wall);
         $display("   actual c=%0d p=%0d f=%0d new=(%0d,%0d) gap=(%0d,%0d) w=%0d",
                  got.carved, got.popped, got.finished, got.new_column, got.new_row,
                  got.gap_column, got.gap_row, got.cell_wall);
      end
   endtask

   // Each result transaction is held against the oldest expectation.
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         seen_answer = {rsp_carved, rsp_popped, rsp_finished, rsp_new_column, rsp_new_row,
                        rsp_gap_column, rsp_gap_row, rsp_cell_wall};
         if (expected_answers.size() == 0) begin
            report_mismatch("Unexpected result", '0, seen_answer);
         end else begin
            wanted_answer = expected_answers.pop_front();
            if (seen_answer !== wanted_answer)
               report_mismatch("Result mismatch", wanted_answer, seen_answer);
         end
      end
   end

   // Before any restart: reads of the cleared grid, a step on an empty trail,
   // a step on a finished maze and the unused kind.
   task automatic test_power_on_state();
      send_command(KIND_READ, 8'd0, 6'd1, 6'd1);
      send_command(KIND_READ, 8'd0, 6'd63, 6'd63);
      send_command(KIND_STEP, 8'd0, 6'd0, 6'd0);
      send_command(KIND_READ, 8'd0, 6'd0, 6'd1);
      send_command(KIND_READ, 8'd0, 6'd14, 6'd13);
      send_command(KIND_STEP, 8'd255, 6'd0, 6'd0);
      send_command(2'd3, 8'd255, 6'd63, 6'd63);
      send_command(KIND_READ, 8'd0, 6'd14, 6'd14);
   endtask

   // Smallest maze, largest maze with extreme picks, and even requests.
   task automatic test_size_extremes();
      settle_block();
      write_reg(CSR_WIDTH_IDX, 6'd0);
      write_reg(CSR_HEIGHT_IDX, 6'd1);
      send_command(KIND_RESTART, 8'd0, 6'd0, 6'd0);
      send_command(KIND_STEP, 8'd128, 6'd0, 6'd0);
      send_command(KIND_STEP, 8'd0, 6'd0, 6'd0);
      send_command(KIND_READ, 8'd0, 6'd2, 6'd1);

      settle_block();
      write_reg(CSR_WIDTH_IDX, 6'd62);
      write_reg(CSR_HEIGHT_IDX, 6'd63);
      send_command(KIND_RESTART, 8'd0, 6'd0, 6'd0);
      send_command(KIND_STEP, 8'd255, 6'd0, 6'd0);
      send_command(KIND_STEP, 8'd0, 6'd0, 6'd0);
      send_command(KIND_STEP, 8'd128, 6'd0, 6'd0);
      send_command(KIND_READ, 8'd0, 6'd0, 6'd0);
      send_command(KIND_READ, 8'd0, 6'd62, 6'd61);
      send_command(KIND_READ, 8'd0, 6'd63, 6'd62);

      settle_block();
      write_reg(CSR_WIDTH_IDX, 6'd4);
      write_reg(CSR_HEIGHT_IDX, 6'd2);
      send_command(KIND_RESTART, 8'd0, 6'd0, 6'd0);
      while (!maze_done)
         send_command(KIND_STEP, 8'($urandom_range(255)), 6'd0, 6'd0);
   endtask

   // Random reads, mostly inside the current grid.
   task automatic send_random_read();
      if ($urandom_range(3) == 0)
         send_command(KIND_READ, 8'($urandom_range(255)), 6'($urandom_range(63)),
                      6'($urandom_range(63)));
      else
         send_command(KIND_READ, 8'($urandom_range(255)), 6'($urandom_range(maze_w - 1)),
                      6'($urandom_range(maze_h - 1)));
   endtask

   // One random maze carved to the end, with reads and noise mixed in.
   task automatic carve_random_maze(input int maze_idx);
      int budget;
      int roll;
      int w_ask;
      int h_ask;
      settle_block();
      w_ask = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(21);
      h_ask = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(21);
      if ($urandom_range(4) != 0) write_reg(CSR_WIDTH_IDX, 6'(w_ask));
      if ($urandom_range(4) != 0) write_reg(CSR_HEIGHT_IDX, 6'(h_ask));
      case (maze_idx % 3)
         0: idle_pct = 0;
         1: idle_pct = 72;
         default: idle_pct = 29;
      endcase
      send_command(KIND_RESTART, 8'($urandom_range(255)), 6'($urandom_range(63)),
                   6'($urandom_range(63)));
      budget = 350;
      while (!maze_done && budget > 0) begin
         budget--;
         roll = $urandom_range(99);
         if (roll < 62)
            send_command(KIND_STEP, 8'($urandom_range(255)), 6'($urandom_range(63)),
                         6'($urandom_range(63)));
         else if (roll < 84)
            send_random_read();
         else if (roll < 88)
            send_command(2'd3, 8'($urandom_range(255)), 6'($urandom_range(63)),
                         6'($urandom_range(63)));
         else if (roll < 90)
            send_command(KIND_RESTART, 8'($urandom_range(255)), 6'd0, 6'd0);
         else
            send_command(KIND_STEP, ($urandom_range(1) != 0) ? 8'd255 : 8'd0, 6'd0, 6'd0);
      end
      // A few transactions on the finished (or abandoned) maze.
      repeat ($urandom_range(0, 2))
         send_command(KIND_STEP, 8'($urandom_range(255)), 6'd0, 6'd0);
      send_random_read();
   endtask

   task automatic test_random_mazes();
      int first;
      int maze_idx;
      first    = work_items;
      maze_idx = 0;
      while (work_items - first < RANDOM_ITEMS) begin
         carve_random_maze(maze_idx);
         maze_idx++;
      end
      idle_pct = 0;
   endtask

   initial begin
      clear_maze_state();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // The grid is cleared after reset before the first transaction is taken.
      do @(posedge clock); while (busy !== 1'b0);
      @(negedge clock);

      test_power_on_state();
      test_size_extremes();
      test_random_mazes();

      settle_block();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && expected_answers.size() == 0) begin
         $display("dfs_maze_carver_top_tb OK");
      end else begin
         $display("dfs_maze_carver_top_tb NOT OK");
      end
      $finish;
   end

endmodule
